### rtl/core/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg: shared types and constants of the ray march column unit
// Word layouts, fixed-point widths, register indexes, sine table builder
// and shade weight table.
// ----------------------------------------------------------------------------
`default_nettype none

package grm_pkg;

  // default sizes
  localparam int MAP_SIDE_DEF    = 32;
  localparam int SINE_ROM_DEF    = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  // fixed-point formats
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = 21;
  localparam int POS_W           = COORD_FRAC_BITS + 19;
  localparam int DOWN_SH         = (COORD_FRAC_BITS > 16) ? COORD_FRAC_BITS - 16 : 0;
  localparam int UP_SH           = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;
  localparam int SPAN_W          = 29;
  localparam longint DIST_CAP    = 64'd1 << 28;
  localparam int SQ_W            = 60;
  localparam int DIST_W          = 29;
  localparam int NUM_W           = 27;
  localparam int DEN_W           = 29;
  localparam int HEIGHT_W        = 16;

  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 16'd34560;
  localparam logic [HEIGHT_W-1:0] SCREEN_H   = 16'd1080;
  localparam logic [HEIGHT_W-1:0] HALF_SCREEN = 16'd540;
  localparam logic [NUM_W-1:0]    HEIGHT_NUM = NUM_W'(1080 * 65536);
  localparam logic [3:0]          TEX_CODE   = 4'd7;

  // shade numerators stay below 2^22; ceil(2^35 / 10800) gives an exact floor
  localparam int SHADE_NUM_W = 22;
  localparam int SHADE_SH    = 35;
  localparam logic [SHADE_NUM_W-1:0] SHADE_RECIP = 22'd3181458;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CAST = 1'b1;

  // configuration registers
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_LIMIT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MARCH_STEP = 1'b1;
  localparam logic [15:0] STEP_LIMIT_RESET = 16'd10000;
  localparam logic [15:0] MARCH_STEP_RESET = 16'd655;

  // sine table construction constants (Q30)
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic                      command;
    logic [4:0]                cell_row;
    logic [4:0]                cell_col;
    logic [3:0]                cell_code;
    logic [COORD_W-1:0]        origin_x;
    logic [COORD_W-1:0]        origin_y;
    logic [15:0]               ray_angle;
    logic signed [15:0]        view_offset;
    logic [10:0]               screen_column;
  } item_t;

  typedef struct packed {
    logic [10:0]               out_column;
    logic [HEIGHT_W-1:0]       wall_height;
    logic signed [15:0]        top_offset;
    logic [3:0]                hit_code;
    logic [6:0]                texture_column;
    logic [7:0]                shade_red;
    logic [7:0]                shade_green;
    logic [7:0]                shade_blue;
    logic                      gave_up;
  } result_t;

  // queued work between front and back
  typedef struct packed {
    logic                      is_cast;
    logic [4:0]                cell_row;
    logic [4:0]                cell_col;
    logic [3:0]                cell_code;
    logic [COORD_W-1:0]        origin_x;
    logic [COORD_W-1:0]        origin_y;
    logic [15:0]               cos_ang;
    logic [15:0]               sin_ang;
    logic [15:0]               view_ang;
    logic [10:0]               column;
  } job_t;

  // one sine entry, round(32767*sin(2*pi*i/2^lg)), elaboration time only
  function automatic logic signed [15:0] sine_entry(input logic [63:0] i, input int lg);
    logic [63:0] u, q, r, x, x2, t, s, v;
    u = i << (32 - lg);
    q = (u >> 30) & 64'd3;
    r = u & (Q30_ONE - 64'd1);
    if (q[0]) begin
      r = Q30_ONE - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return (q >= 64'd2) ? -signed'(v[15:0]) : signed'(v[15:0]);
  endfunction

  // displacement brought to Q.16 and saturated at 4096 cells
  function automatic logic [SPAN_W-1:0] span_q16(input logic signed [POS_W-1:0] d);
    logic [POS_W-1:0] mag;
    logic [POS_W+7:0] m;
    mag = d[POS_W-1] ? POS_W'(-d) : POS_W'(d);
    m   = (POS_W+8)'(mag >> DOWN_SH) << UP_SH;
    if (m > (POS_W+8)'(DIST_CAP)) begin
      return SPAN_W'(DIST_CAP);
    end
    return SPAN_W'(m);
  endfunction

  // shade weight in tenths by code and channel (0 red, 1 green, 2 blue)
  function automatic logic [3:0] shade_tenths(input logic [3:0] code, input logic [1:0] ch);
    logic [3:0] w;
    w = 4'd0;
    case (code)
      4'd0, 4'd7: w = 4'd10;
      4'd1:       w = (ch == 2'd0) ? 4'd10 : 4'd0;
      4'd2:       w = (ch == 2'd1) ? 4'd10 : 4'd0;
      4'd3:       w = (ch == 2'd2) ? 4'd10 : 4'd0;
      4'd4:       w = (ch == 2'd0) ? 4'd7 : 4'd3;
      default:    w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/grm_front.sv
// ----------------------------------------------------------------------------
// grm_front: input side of the ray march column unit
// Accepts words, drops loads outside the map and turns casts and the other
// loads into queue jobs with their three lookup angles.
// ----------------------------------------------------------------------------
`default_nettype none

module grm_front #(
  parameter int MAP_SIDE = grm_pkg::MAP_SIDE_DEF
) (
  input  logic           item_valid,
  input  grm_pkg::item_t item,
  input  logic           q_full,
  input  logic           clearing,
  output logic           item_stall,
  output logic           push,
  output grm_pkg::job_t  job
);
  import grm_pkg::*;

  logic take;
  logic in_range;

  // hold off while the queue is full or the map is being cleared
  assign item_stall = q_full | clearing;
  assign take       = item_valid & ~item_stall;

  // loads outside the map are dropped here
  assign in_range = (9'(item.cell_row) < 9'(MAP_SIDE)) && (9'(item.cell_col) < 9'(MAP_SIDE));
  assign push     = take & ((item.command == CMD_CAST) | in_range);

  // job build: cosine taken as sine a quarter turn ahead
  always_comb begin
    job.is_cast   = (item.command == CMD_CAST);
    job.cell_row  = item.cell_row;
    job.cell_col  = item.cell_col;
    job.cell_code = item.cell_code;
    job.origin_x  = item.origin_x;
    job.origin_y  = item.origin_y;
    job.cos_ang   = item.ray_angle + 16'd16384;
    job.sin_ang   = item.ray_angle;
    job.view_ang  = 16'(item.view_offset) + 16'd16384;
    job.column    = item.screen_column;
  end

endmodule

`default_nettype wire

### rtl/core/grm_queue.sv
// ----------------------------------------------------------------------------
// grm_queue: short job queue between front and back
// Register-based circular buffer with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module grm_queue #(
  parameter int DEPTH = grm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  grm_pkg::job_t wdata,
  input  logic          pop,
  output grm_pkg::job_t rdata,
  output logic          full,
  output logic          not_empty
);
  import grm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  job_t            slots [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue write while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

### rtl/core/grm_div.sv
// ----------------------------------------------------------------------------
// grm_div: iterative restoring divider
// One quotient bit per cycle, used for the height division.
// ----------------------------------------------------------------------------
`default_nettype none

module grm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [grm_pkg::NUM_W-1:0] num,
  input  logic [grm_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [grm_pkg::NUM_W-1:0] quot
);
  import grm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] qsh;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem[DEN_W-1:0], qsh[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign quot  = qsh;

  // one shift-subtract step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        qsh   <= num;
        den_q <= den;
      end else if (busy) begin
        rem <= ge ? trial - {1'b0, den_q} : trial;
        qsh <= {qsh[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/grm_back.sv
// ----------------------------------------------------------------------------
// grm_back: execution side of the ray march column unit
// Owns the wall map and sine table, writes loads, marches casts, then
// measures, divides (skipped when the height is forced) and shades into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module grm_back #(
  parameter int MAP_SIDE         = grm_pkg::MAP_SIDE_DEF,
  parameter int SINE_ROM_ENTRIES = grm_pkg::SINE_ROM_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      step_limit,
  input  logic [15:0]      march_step,
  input  logic             q_valid,
  input  grm_pkg::job_t    q_job,
  output logic             pop,
  output logic             clearing,
  output grm_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall
);
  import grm_pkg::*;

  localparam int F        = COORD_FRAC_BITS;
  localparam int ROM_AW   = $clog2(SINE_ROM_ENTRIES);
  localparam int CELLS    = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int IDX_W    = $clog2(MAP_SIDE);
  localparam int CIDX_W   = POS_W - F;
  localparam int SQ_CNT_W = $clog2(SQ_W / 2);
  localparam int RQ_W     = 2 * SHADE_NUM_W;
  localparam logic [SQ_W-1:0] SQRT_TOP = SQ_W'(1) << (SQ_W - 2);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ROM_COS, S_ROM_SIN, S_ROM_VIEW, S_ROM_LAST,
    S_MARCH_RD, S_MARCH_TST, S_SPAN, S_SQ_X, S_SQ_Y, S_SQ_SUM, S_SQRT,
    S_CORR, S_H_SEL, S_DIV_GO, S_DIV_WAIT, S_SHADE_NUM, S_SHADE_MUL, S_FINISH
  } state_t;

  typedef logic signed [15:0] sine_tab_t [SINE_ROM_ENTRIES];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int i = 0; i < SINE_ROM_ENTRIES; i++) begin
      tab[i] = sine_entry(64'(i), ROM_AW);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE = build_sine();

  // march increment from a sine value and the step length
  function automatic logic signed [POS_W-1:0] step_of(input logic signed [15:0] trig,
                                                      input logic [15:0] stp);
    logic [15:0]              mag;
    logic [31:0]              prod;
    logic signed [POS_W-1:0]  sv;
    mag  = trig[15] ? 16'(-trig) : 16'(trig);
    prod = mag * stp;
    sv   = signed'(POS_W'(prod >> (31 - F)));
    return trig[15] ? -sv : sv;
  endfunction

  // quotient to one shade channel
  function automatic logic [7:0] pick(input logic [3:0] w, input logic [7:0] q10,
                                      input logic [7:0] q7, input logic [7:0] q3);
    logic [7:0] r;
    case (w)
      4'd10:   r = q10;
      4'd7:    r = q7;
      4'd3:    r = q3;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  state_t                   state;
  job_t                     job;
  logic [ADDR_W-1:0]        clr_cnt;
  logic signed [POS_W-1:0]  x, y, dx, dy;
  logic [16:0]              n;
  logic                     gave;
  logic [3:0]               code;
  logic signed [15:0]       cb;
  logic [SPAN_W-1:0]        fx, fy;
  logic [2*SPAN_W-1:0]      sqa, sqb;
  logic [SQ_W-1:0]          rad, root, sbit;
  logic [SQ_CNT_W-1:0]      sq_cnt;
  logic [DIST_W-1:0]        corr;
  logic [HEIGHT_W-1:0]      height;
  logic [7:0]               q10, q7, q3;
  logic [SHADE_NUM_W-1:0]   shn10, shn7, shn3;

  logic [3:0]               cells [CELLS];
  logic [3:0]               cell_q;
  logic                     outside_q;
  logic signed [15:0]       rom_q;
  logic [ROM_AW-1:0]        rom_idx;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [3:0]               wr_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     outside;
  logic [CIDX_W-1:0]        cx, cy;
  logic [3:0]               cell_now;
  logic [SPAN_W-1:0]        sq_sel;
  logic [2*SPAN_W-1:0]      sq_prod;
  logic [SQ_W-1:0]          sq_trial;
  logic [14:0]              cb_mag;
  logic [DIST_W+14:0]       corr_prod;
  logic [10:0]              sh;
  logic [RQ_W-1:0]          rq10, rq7, rq3;
  logic                     div_start, div_busy, div_done;
  logic [NUM_W-1:0]         div_num, div_quot;
  logic [DEN_W-1:0]         div_den;
  logic [F-1:0]             px, py;
  logic [6:0]               fxc, fyc, tex;
  result_t                  res_next;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && q_valid;

  // map write port: clearing sweep or load
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt;
    wr_data = 4'd0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (pop && !q_job.is_cast) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(32'(q_job.cell_row) * MAP_SIDE + 32'(q_job.cell_col));
      wr_data = q_job.cell_code;
    end
  end

  // map read address from the current ray position
  assign cx      = CIDX_W'(x >>> F);
  assign cy      = CIDX_W'(y >>> F);
  assign outside = x[POS_W-1] | y[POS_W-1] |
                   (cx >= CIDX_W'(MAP_SIDE)) | (cy >= CIDX_W'(MAP_SIDE));
  assign rd_addr = ADDR_W'(32'(cy[IDX_W-1:0]) * MAP_SIDE + 32'(cx[IDX_W-1:0]));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    cell_q    <= cells[rd_addr];
    outside_q <= outside;
  end

  assign cell_now = outside_q ? 4'd1 : cell_q;

  // sine table read
  always_comb begin
    case (state)
      S_ROM_COS: rom_idx = job.cos_ang[15 -: ROM_AW];
      S_ROM_SIN: rom_idx = job.sin_ang[15 -: ROM_AW];
      default:   rom_idx = job.view_ang[15 -: ROM_AW];
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE[rom_idx];
  end

  // shared squarer and root step
  assign sq_sel   = (state == S_SQ_X) ? fx : fy;
  assign sq_prod  = sq_sel * sq_sel;
  assign sq_trial = root + sbit;

  // cosine correction
  assign cb_mag    = cb[15] ? 15'(-cb) : 15'(cb);
  assign corr_prod = root[DIST_W-1:0] * cb_mag;

  // height division operands
  assign div_num   = HEIGHT_NUM;
  assign div_den   = corr;
  assign div_start = (state == S_DIV_GO);

  grm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // shade: weighted numerators over 10800 by reciprocal multiply
  assign sh   = (height > SCREEN_H) ? 11'(SCREEN_H) : height[10:0];
  assign rq10 = RQ_W'(shn10) * RQ_W'(SHADE_RECIP);
  assign rq7  = RQ_W'(shn7) * RQ_W'(SHADE_RECIP);
  assign rq3  = RQ_W'(shn3) * RQ_W'(SHADE_RECIP);

  // texture column for the textured code
  assign px  = x[F-1:0];
  assign py  = y[F-1:0];
  assign fxc = 7'((32'(px) * 32'd100) >> F);
  assign fyc = 7'((32'(py) * 32'd100) >> F);
  assign tex = (code == TEX_CODE) ? ((fxc > 7'd1) ? fxc : fyc) : 7'd0;

  // result word
  always_comb begin
    res_next.out_column     = job.column;
    res_next.wall_height    = height;
    res_next.top_offset     = signed'(HALF_SCREEN - {1'b0, height[HEIGHT_W-1:1]});
    res_next.hit_code       = code;
    res_next.texture_column = tex;
    res_next.shade_red      = pick(shade_tenths(code, 2'd0), q10, q7, q3);
    res_next.shade_green    = pick(shade_tenths(code, 2'd1), q10, q7, q3);
    res_next.shade_blue     = pick(shade_tenths(code, 2'd2), q10, q7, q3);
    res_next.gave_up        = gave;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_FINISH) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(CELLS-1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid && q_job.is_cast) begin
            job   <= q_job;
            x     <= signed'(POS_W'(q_job.origin_x));
            y     <= signed'(POS_W'(q_job.origin_y));
            n     <= '0;
            gave  <= 1'b0;
            state <= S_ROM_COS;
          end
        end
        S_ROM_COS: state <= S_ROM_SIN;
        S_ROM_SIN: begin
          dx    <= step_of(rom_q, march_step);
          state <= S_ROM_VIEW;
        end
        S_ROM_VIEW: begin
          dy    <= step_of(rom_q, march_step);
          state <= S_ROM_LAST;
        end
        S_ROM_LAST: begin
          cb    <= rom_q;
          state <= S_MARCH_RD;
        end
        S_MARCH_RD: state <= S_MARCH_TST;
        S_MARCH_TST: begin
          if (cell_now != 4'd0 || gave) begin
            code  <= cell_now;
            state <= S_SPAN;
          end else begin
            x <= x + dx;
            y <= y + dy;
            if (n > {1'b0, step_limit}) begin
              gave <= 1'b1;
            end else begin
              n <= n + 1'b1;
            end
            state <= S_MARCH_RD;
          end
        end
        S_SPAN: begin
          fx    <= span_q16(x - signed'(POS_W'(job.origin_x)));
          fy    <= span_q16(y - signed'(POS_W'(job.origin_y)));
          state <= S_SQ_X;
        end
        S_SQ_X: begin
          sqa   <= sq_prod;
          state <= S_SQ_Y;
        end
        S_SQ_Y: begin
          sqb   <= sq_prod;
          state <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          rad    <= SQ_W'(sqa) + SQ_W'(sqb);
          root   <= '0;
          sbit   <= SQRT_TOP;
          sq_cnt <= '0;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          if (rad >= sq_trial) begin
            rad  <= rad - sq_trial;
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit   <= sbit >> 2;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == SQ_CNT_W'(SQ_W/2 - 1)) begin
            state <= S_CORR;
          end
        end
        S_CORR: begin
          corr  <= corr_prod[DIST_W+14:15];
          state <= S_H_SEL;
        end
        S_H_SEL: begin
          if (corr == '0) begin
            height <= MAX_HEIGHT;
            state  <= S_SHADE_NUM;
          end else if (cb[15]) begin
            height <= 16'd1;
            state  <= S_SHADE_NUM;
          end else begin
            state  <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (div_quot > NUM_W'(MAX_HEIGHT)) begin
              height <= MAX_HEIGHT;
            end else if (div_quot == '0) begin
              height <= 16'd1;
            end else begin
              height <= div_quot[HEIGHT_W-1:0];
            end
            state <= S_SHADE_NUM;
          end
        end
        S_SHADE_NUM: begin
          shn10 <= SHADE_NUM_W'(sh) * 22'd2550;
          shn7  <= SHADE_NUM_W'(sh) * 22'd1785;
          shn3  <= SHADE_NUM_W'(sh) * 22'd765;
          state <= S_SHADE_MUL;
        end
        S_SHADE_MUL: begin
          q10   <= rq10[SHADE_SH+7:SHADE_SH];
          q7    <= rq7[SHADE_SH+7:SHADE_SH];
          q3    <= rq3[SHADE_SH+7:SHADE_SH];
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result       <= res_next;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_GO) |-> !div_busy)
    else $error("divider started while busy");
  a_height_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> (height >= 16'd1 && height <= MAX_HEIGHT))
    else $error("wall height out of range");
  a_give_up_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARCH_TST && gave) |=> (state == S_SPAN))
    else $error("march kept going after giving up");

endmodule

`default_nettype wire

### rtl/core/grid_ray_march_column_unit.sv
// flow: a taken load waits in the queue and is written to the map when the back end
//   pops it; a cast does its sine reads, then a map read and a test per march step
// capacity: one cast at a time in the march unit; up to QUEUE_DEPTH words
//   wait in the queue, and a finished result waits in its own output register
// reset: the MAP_SIDE*MAP_SIDE map cells (1024 by default) are cleared one cell a
//   cycle, with item_stall high; registers return to 10000 and 655
// ----------------------------------------------------------------------------
// grid_ray_march_column_unit: fixed-step grid ray caster, one column a cast
// Front classifies words, a short queue decouples it from the march back end.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_march_column_unit #(
  parameter int MAP_SIDE         = grm_pkg::MAP_SIDE_DEF,
  parameter int SINE_ROM_ENTRIES = grm_pkg::SINE_ROM_DEF,
  parameter int QUEUE_DEPTH      = grm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  grm_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output grm_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [grm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);
  import grm_pkg::*;

  logic [15:0] step_limit;
  logic [15:0] march_step;
  logic        push, pop, q_full, q_not_empty, clearing;
  job_t        push_job, head_job;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= STEP_LIMIT_RESET;
      march_step <= MARCH_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_LIMIT: step_limit <= cfg_data;
        REG_MARCH_STEP: march_step <= cfg_data;
        default: ;
      endcase
    end
  end

  grm_front #(.MAP_SIDE(MAP_SIDE)) u_front (
    .item_valid (item_valid),
    .item       (item),
    .q_full     (q_full),
    .clearing   (clearing),
    .item_stall (item_stall),
    .push       (push),
    .job        (push_job)
  );

  grm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (push_job),
    .pop       (pop),
    .rdata     (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  grm_back #(
    .MAP_SIDE         (MAP_SIDE),
    .SINE_ROM_ENTRIES (SINE_ROM_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .step_limit   (step_limit),
    .march_step   (march_step),
    .q_valid      (q_not_empty),
    .q_job        (head_job),
    .pop          (pop),
    .clearing     (clearing),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire
